// File: rtl/cbmv_pkg.sv
package cbmv_pkg;

   localparam int N_MAX      = 64;
   localparam int R_MAX      = 16;
   localparam int COEF_WIDTH = 16;
   localparam int FRAC       = COEF_WIDTH - 2;
   localparam int IDX_W      = 6;
   localparam int RANK_W     = 4;
   localparam int CNT_W      = 7;
   localparam int ACC_W      = 48;
   localparam int RES_W      = 32;

   localparam logic [1:0] OP_MATRIX  = 2'd0;
   localparam logic [1:0] OP_VFACTOR = 2'd1;
   localparam logic [1:0] OP_VECTOR  = 2'd2;

   localparam logic [1:0] CSR_ROW_COUNT  = 2'd0;
   localparam logic [1:0] CSR_COL_COUNT  = 2'd1;
   localparam logic [1:0] CSR_LOW_RANK   = 2'd2;
   localparam logic [1:0] CSR_RANK_COUNT = 2'd3;

   typedef struct packed {
      logic [1:0]                   operation;
      logic [IDX_W-1:0]             row_index;
      logic [IDX_W-1:0]             col_index;
      logic signed [COEF_WIDTH-1:0] value_re;
      logic signed [COEF_WIDTH-1:0] value_im;
      logic                         last;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]        out_row;
      logic signed [RES_W-1:0] result_re;
      logic signed [RES_W-1:0] result_im;
      logic                    saturated;
      logic                    last_row;
   } rsp_type;

   typedef struct packed {
      logic             valid;
      logic             start;
      logic             first;
      logic             last;
      logic             a_v;
      logic             b_t;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic             final_row;
   } cmd_type;

   typedef struct packed {
      logic done;
      logic out_busy;
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_TISSUE,
      S_TWAIT,
      S_RISSUE,
      S_RWAIT,
      S_RHOLD
   } state_type;

endpackage

// File: rtl/cbmv_ctrl.sv
module cbmv_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                factored,
   input  logic [6:0]          rows,
   input  logic [6:0]          cols,
   input  logic [6:0]          rank,
   input  cbmv_pkg::status_type status,
   output cbmv_pkg::cmd_type   cmd,
   output logic                idle
);
   import cbmv_pkg::*;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] o_ff, o_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0] n_inner;
   logic             inner_last;
   logic             outer_last_t;
   logic             outer_last_r;

   assign n_inner      = (state_ff == S_TISSUE) ? cols : (factored ? rank : cols);
   assign inner_last   = ({1'b0, j_ff} == n_inner - 7'd1);
   assign outer_last_t = ({1'b0, o_ff} == rank - 7'd1);
   assign outer_last_r = ({1'b0, o_ff} == rows - 7'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         o_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         o_ff     <= o_in;
         j_ff     <= j_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (start) state_in = factored ? S_TISSUE : S_RISSUE;
         S_TISSUE: if (inner_last) state_in = S_TWAIT;
         S_TWAIT:  if (status.done) state_in = outer_last_t ? S_RISSUE : S_TISSUE;
         S_RISSUE: if (inner_last) state_in = S_RWAIT;
         S_RWAIT:  if (status.done) state_in = S_RHOLD;
         S_RHOLD:  if (!status.out_busy) state_in = outer_last_r ? S_IDLE : S_RISSUE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      o_in          = o_ff;
      j_in          = j_ff;
      cmd           = '0;
      cmd.start     = start && (state_ff == S_IDLE);
      cmd.row       = o_ff;
      cmd.col       = j_ff;
      cmd.first     = (j_ff == '0);
      cmd.last      = inner_last;
      cmd.final_row = outer_last_r;
      idle          = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            o_in = '0;
            j_in = '0;
         end
         S_TISSUE: begin
            cmd.valid = 1'b1;
            cmd.a_v   = 1'b1;
            j_in      = inner_last ? '0 : j_ff + 6'd1;
         end
         S_TWAIT: begin
            if (status.done) o_in = outer_last_t ? '0 : o_ff + 6'd1;
         end
         S_RISSUE: begin
            cmd.valid = 1'b1;
            cmd.b_t   = factored;
            j_in      = inner_last ? '0 : j_ff + 6'd1;
         end
         S_RWAIT: begin
         end
         S_RHOLD: begin
            if (!status.out_busy && !outer_last_r) o_in = o_ff + 6'd1;
         end
         default: begin
         end
      endcase
   end

endmodule

// File: rtl/cbmv_datapath.sv
module cbmv_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  cbmv_pkg::req_type   wr_item,
   input  cbmv_pkg::cmd_type   cmd,
   output cbmv_pkg::status_type status,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output cbmv_pkg::rsp_type   rsp_item
);
   import cbmv_pkg::*;

   localparam int CW = COEF_WIDTH;
   localparam logic signed [ACC_W-1:0] ACC_HI = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_LO = {1'b1, {(ACC_W-1){1'b0}}};

   logic [2*CW-1:0]    matrix_mem [N_MAX*N_MAX];
   logic [2*CW-1:0]    vfactor_mem [R_MAX*N_MAX];
   logic [2*CW-1:0]    vector_mem [N_MAX];
   logic [2*RES_W-1:0] temp_mem [R_MAX];

   logic [2*CW-1:0]    m_rd_ff, v_rd_ff, x_rd_ff;
   logic [2*RES_W-1:0] t_rd_ff;

   cmd_type tok1_ff, tok2_ff, tok3_ff, tok4_ff;
   logic    v1_ff, v2_ff, v3_ff;

   logic signed [CW-1:0]    a_re, a_im;
   logic signed [RES_W-1:0] b_re, b_im;
   logic signed [ACC_W-1:0] rr_ff, ii_ff, ri_ff, ir_ff;
   logic signed [ACC_W:0]   pr_w, pi_w;
   logic signed [ACC_W-1:0] pr_ff, pi_ff, pr_in, pi_in;
   logic                    c3_ff, c3_in;
   logic signed [ACC_W:0]   sr_w, si_w;
   logic signed [ACC_W-1:0] acc_re_ff, acc_im_ff, acc_re_in, acc_im_in;
   logic                    pflag_ff, pflag_in;
   logic                    fin_ff, done_ff, gflag_ff;
   logic signed [ACC_W:0]   rnd_re, rnd_im;
   logic signed [ACC_W-FRAC:0] sh_re, sh_im;
   logic signed [RES_W-1:0] y_re, y_im;
   logic                    sat_re, sat_im, fflag;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff;

   // Load writes and registered reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         case (wr_item.operation)
            OP_MATRIX:
               matrix_mem[{wr_item.row_index, wr_item.col_index}] <=
                  {wr_item.value_re, wr_item.value_im};
            OP_VFACTOR:
               if (wr_item.row_index < IDX_W'(R_MAX))
                  vfactor_mem[{wr_item.row_index[RANK_W-1:0], wr_item.col_index}] <=
                     {wr_item.value_re, wr_item.value_im};
            OP_VECTOR:
               vector_mem[wr_item.col_index] <= {wr_item.value_re, wr_item.value_im};
            default: begin
            end
         endcase
      end
      m_rd_ff <= matrix_mem[{cmd.row, cmd.col}];
      v_rd_ff <= vfactor_mem[{cmd.row[RANK_W-1:0], cmd.col}];
      x_rd_ff <= vector_mem[cmd.col];
      t_rd_ff <= temp_mem[cmd.col[RANK_W-1:0]];
      if (fin_ff && tok4_ff.a_v) temp_mem[tok4_ff.row[RANK_W-1:0]] <= {y_re, y_im};
   end

   always_comb begin
      a_re = tok1_ff.a_v ? v_rd_ff[2*CW-1:CW] : m_rd_ff[2*CW-1:CW];
      a_im = tok1_ff.a_v ? v_rd_ff[CW-1:0]    : m_rd_ff[CW-1:0];
      if (tok1_ff.b_t) begin
         b_re = t_rd_ff[2*RES_W-1:RES_W];
         b_im = t_rd_ff[RES_W-1:0];
      end else begin
         b_re = RES_W'($signed(x_rd_ff[2*CW-1:CW]));
         b_im = RES_W'($signed(x_rd_ff[CW-1:0]));
      end
   end

   // Product clip, then accumulate with clip.
   always_comb begin
      pr_w  = {rr_ff[ACC_W-1], rr_ff} - {ii_ff[ACC_W-1], ii_ff};
      pi_w  = {ri_ff[ACC_W-1], ri_ff} + {ir_ff[ACC_W-1], ir_ff};
      c3_in = 1'b0;
      pr_in = pr_w[ACC_W-1:0];
      pi_in = pi_w[ACC_W-1:0];
      if (pr_w[ACC_W] != pr_w[ACC_W-1]) begin
         pr_in = pr_w[ACC_W] ? ACC_LO : ACC_HI;
         c3_in = 1'b1;
      end
      if (pi_w[ACC_W] != pi_w[ACC_W-1]) begin
         pi_in = pi_w[ACC_W] ? ACC_LO : ACC_HI;
         c3_in = 1'b1;
      end

      sr_w = (tok3_ff.first ? '0 : {acc_re_ff[ACC_W-1], acc_re_ff}) + {pr_ff[ACC_W-1], pr_ff};
      si_w = (tok3_ff.first ? '0 : {acc_im_ff[ACC_W-1], acc_im_ff}) + {pi_ff[ACC_W-1], pi_ff};
      pflag_in  = (tok3_ff.first ? 1'b0 : pflag_ff) | c3_ff;
      acc_re_in = sr_w[ACC_W-1:0];
      acc_im_in = si_w[ACC_W-1:0];
      if (sr_w[ACC_W] != sr_w[ACC_W-1]) begin
         acc_re_in = sr_w[ACC_W] ? ACC_LO : ACC_HI;
         pflag_in  = 1'b1;
      end
      if (si_w[ACC_W] != si_w[ACC_W-1]) begin
         acc_im_in = si_w[ACC_W] ? ACC_LO : ACC_HI;
         pflag_in  = 1'b1;
      end
   end

   // Round half up, shift to Q17.14 and saturate to 32 bits.
   always_comb begin
      rnd_re = {acc_re_ff[ACC_W-1], acc_re_ff} + (ACC_W+1)'(1 << (FRAC-1));
      rnd_im = {acc_im_ff[ACC_W-1], acc_im_ff} + (ACC_W+1)'(1 << (FRAC-1));
      sh_re  = rnd_re[ACC_W:FRAC];
      sh_im  = rnd_im[ACC_W:FRAC];
      sat_re = (sh_re[ACC_W-FRAC:RES_W-1] != {(ACC_W-FRAC-RES_W+2){sh_re[ACC_W-FRAC]}});
      sat_im = (sh_im[ACC_W-FRAC:RES_W-1] != {(ACC_W-FRAC-RES_W+2){sh_im[ACC_W-FRAC]}});
      y_re   = sat_re ? (sh_re[ACC_W-FRAC] ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}})
                      : sh_re[RES_W-1:0];
      y_im   = sat_im ? (sh_im[ACC_W-FRAC] ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}})
                      : sh_im[RES_W-1:0];
      fflag  = pflag_ff | sat_re | sat_im | gflag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         fin_ff       <= 1'b0;
         done_ff      <= 1'b0;
         gflag_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff   <= cmd.valid;
         v2_ff   <= v1_ff;
         v3_ff   <= v2_ff;
         fin_ff  <= v3_ff && tok3_ff.last;
         done_ff <= fin_ff;
         if (cmd.start) gflag_ff <= 1'b0;
         else if (fin_ff && tok4_ff.a_v) gflag_ff <= fflag;
         if (fin_ff && !tok4_ff.a_v) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      tok1_ff <= cmd;
      tok2_ff <= tok1_ff;
      rr_ff   <= a_re * b_re;
      ii_ff   <= a_im * b_im;
      ri_ff   <= a_re * b_im;
      ir_ff   <= a_im * b_re;
      tok3_ff <= tok2_ff;
      pr_ff   <= pr_in;
      pi_ff   <= pi_in;
      c3_ff   <= c3_in;
      if (v3_ff) begin
         tok4_ff   <= tok3_ff;
         acc_re_ff <= acc_re_in;
         acc_im_ff <= acc_im_in;
         pflag_ff  <= pflag_in;
      end
      if (fin_ff && !tok4_ff.a_v) begin
         rsp_ff.out_row   <= tok4_ff.row;
         rsp_ff.result_re <= y_re;
         rsp_ff.result_im <= y_im;
         rsp_ff.saturated <= fflag;
         rsp_ff.last_row  <= tok4_ff.final_row;
      end
   end

   assign status.done     = done_ff;
   assign status.out_busy = rsp_valid_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_item        = rsp_ff;

endmodule

// File: rtl/complex_block_matvec_core.sv
// Complex matrix-vector multiply for one block covering the whole matrix.
// Items with operation 0, 1 and 2 load dense/U entries, V entries and x
// elements. An x element with last set starts the multiply, and while it
// runs no item is accepted. Dense mode computes y = D*x; low-rank mode
// first forms temp = V*x and then y = U*temp. The shared complex
// multiply-accumulate pipeline takes one term per cycle. Each temp entry
// sums cols terms, and each row sums n terms, where n is cols in dense
// mode and rank in low-rank mode. One result item is emitted per row in
// row order, and the next row starts only after the previous result item
// has been taken. Store entries that were never written read as arbitrary
// values. Configuration registers are row_count, col_count, low_rank_mode
// and rank_count at indexes 0 to 3; out-of-range counts are clamped, but
// rank_count keeps only the low five bits of its data before clamping.
module complex_block_matvec_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cbmv_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cbmv_pkg::rsp_type rsp_item,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [6:0]        csr_data
);
   import cbmv_pkg::*;

   logic [6:0] row_count_ff, col_count_ff;
   logic [4:0] rank_count_ff;
   logic       low_rank_ff;
   logic [6:0] rows, cols, rank;
   logic       idle, wr_en, start;
   cmd_type    cmd;
   status_type status;

   // Configuration registers; the port never stalls.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff  <= 7'd64;
         col_count_ff  <= 7'd64;
         low_rank_ff   <= 1'b0;
         rank_count_ff <= 5'd1;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ROW_COUNT:  row_count_ff  <= csr_data;
            CSR_COL_COUNT:  col_count_ff  <= csr_data;
            CSR_LOW_RANK:   low_rank_ff   <= csr_data[0];
            CSR_RANK_COUNT: rank_count_ff <= csr_data[4:0];
            default: begin
            end
         endcase
      end
   end

   // Clamp the counts into their legal ranges.
   always_comb begin
      rows = (row_count_ff == '0) ? 7'd1 :
             (row_count_ff > 7'(N_MAX)) ? 7'(N_MAX) : row_count_ff;
      cols = (col_count_ff == '0) ? 7'd1 :
             (col_count_ff > 7'(N_MAX)) ? 7'(N_MAX) : col_count_ff;
      rank = (rank_count_ff == '0) ? 7'd1 :
             ({2'b0, rank_count_ff} > 7'(R_MAX)) ? 7'(R_MAX) : {2'b0, rank_count_ff};
   end

   // Loads are taken only while idle and no result item is pending.
   assign req_ready = idle && !status.out_busy;
   assign wr_en     = req_valid && req_ready;
   assign start     = wr_en && (req_item.operation == OP_VECTOR) && req_item.last;

   cbmv_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .factored (low_rank_ff),
      .rows     (rows),
      .cols     (cols),
      .rank     (rank),
      .status   (status),
      .cmd      (cmd),
      .idle     (idle)
   );

   cbmv_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (wr_en),
      .wr_item   (req_item),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule
